// ----- rtl/triangle_scanline_span_fill_defines.svh -----
// assertion macros for the triangle span fill checker
`ifndef TRIANGLE_SCANLINE_SPAN_FILL_DEFINES_SVH
`define TRIANGLE_SCANLINE_SPAN_FILL_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TSSF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tssf: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TSSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tssf: next-cycle check failed");

`endif

// ----- rtl/tssf_pkg.sv -----
// shared types and constants of the triangle span fill block
`timescale 1ns / 1ps
package tssf_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOUR_BITS = 24;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [COLOUR_BITS-1:0]       fill_colour;
  } tri_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] row;
    logic signed [COORD_BITS-1:0] x_from;
    logic signed [COORD_BITS-1:0] x_to;
    logic [COLOUR_BITS-1:0]       span_colour;
    logic                         last_span;
  } span_t;

  typedef enum logic [1:0] {
    KIND_FLAT_BOTTOM,
    KIND_FLAT_TOP,
    KIND_SPLIT
  } tri_kind_t;

  typedef enum logic [1:0] {
    DSEL_RATIO,
    DSEL_S1,
    DSEL_S2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_go;
    div_sel_t div_sel;
    logic     mq_mul;
    logic     mq_add;
    logic     setup;
    logic     pass;
    logic     calc_range;
    logic     x_mul;
    logic     x_init;
    logic     step;
    logic     flush;
  } dp_cmd_t;

  typedef struct packed {
    tri_kind_t kind;
    logic      div_done;
    logic      empty;
    logic      at_end;
  } dp_status_t;

endpackage

// ----- rtl/tssf_div.sv -----
// iterative signed divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tssf_div #(
  parameter int NW = 30,
  parameter int DW = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [NW-1:0] quot
);
  localparam int CW = $clog2(NW);

  logic          run;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [NW-1:0] mag;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem;

  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_next;
  logic [NW-1:0] mag_next;

  always_comb begin
    rem_sh   = {rem[DW-1:0], mag[NW-1]};
    ge       = rem_sh >= {1'b0, den_r};
    rem_next = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
    mag_next = {mag[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        cnt   <= '0;
        neg   <= num[NW-1];
        mag   <= num[NW-1] ? NW'(-num) : NW'(num);
        den_r <= den;
        rem   <= '0;
      end else if (run) begin
        rem <= rem_next;
        mag <= mag_next;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
          // zero height gives slope zero
          if (den_r == '0) quot <= '0;
          else if (neg) quot <= -$signed(mag_next);
          else quot <= $signed(mag_next);
        end
      end
    end
  end
endmodule

// ----- rtl/tssf_dp.sv -----
// datapath: vertex sort, slopes, edge stepping and span output
`timescale 1ns / 1ps
module tssf_dp #(
  parameter int BAND_ROWS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [tssf_pkg::COORD_BITS-1:0] band_top,
  input  tssf_pkg::tri_in_t                     triangle,
  input  tssf_pkg::dp_cmd_t                     cmd,
  output tssf_pkg::dp_status_t                  status,
  output logic                                  span_valid,
  output tssf_pkg::span_t                       span
);
  import tssf_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int W  = C + FRAC_BITS + 3;
  localparam int NW = C + FRAC_BITS + 2;
  localparam int RW = C + 2;
  localparam int TW = W - FRAC_BITS;
  localparam int PW = C + 1 + W;
  localparam int MW = FRAC_BITS + C + 2;
  localparam logic signed [W-1:0]  HALF = W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [TW-1:0] XMAX = TW'((longint'(1) << (C - 1)) - 1);
  localparam logic signed [TW-1:0] XMIN = TW'(-(longint'(1) << (C - 1)));

  function automatic logic signed [W-1:0] to_q(input logic signed [C-1:0] v);
    to_q = W'(v) <<< FRAC_BITS;
  endfunction

  // truncate toward zero, then clamp to the coordinate range
  function automatic logic signed [C-1:0] sat_x(input logic signed [W-1:0] q);
    logic signed [TW-1:0] t;
    t = $signed(q[W-1:FRAC_BITS]);
    if (q[W-1] && (|q[FRAC_BITS-1:0])) t = t + TW'(1);
    if (t > XMAX) t = XMAX;
    else if (t < XMIN) t = XMIN;
    sat_x = t[C-1:0];
  endfunction

  // sorted vertices
  logic signed [C-1:0] v0x, v0y, v1x, v1y, v2x, v2y;
  logic [COLOUR_BITS-1:0] colour;

  // sort network
  logic signed [C-1:0] ax1, ay1, bx1, by1, ax2, ay2, cx1, cy1, bx2, by2, cx2, cy2;
  always_comb begin
    if (triangle.ay > triangle.by_coord) begin
      ax1 = triangle.bx; ay1 = triangle.by_coord; bx1 = triangle.ax; by1 = triangle.ay;
    end else begin
      ax1 = triangle.ax; ay1 = triangle.ay; bx1 = triangle.bx; by1 = triangle.by_coord;
    end
    if (ay1 > triangle.cy) begin
      ax2 = triangle.cx; ay2 = triangle.cy; cx1 = ax1; cy1 = ay1;
    end else begin
      ax2 = ax1; ay2 = ay1; cx1 = triangle.cx; cy1 = triangle.cy;
    end
    if (by1 > cy1) begin
      bx2 = cx1; by2 = cy1; cx2 = bx1; cy2 = by1;
    end else begin
      bx2 = bx1; by2 = by1; cx2 = cx1; cy2 = cy1;
    end
  end

  tri_kind_t kind;
  always_comb begin
    if (v1y == v2y) kind = KIND_FLAT_BOTTOM;
    else if (v0y == v1y) kind = KIND_FLAT_TOP;
    else kind = KIND_SPLIT;
  end

  // split point and pass descriptor
  logic [FRAC_BITS-1:0]  ratio;
  logic signed [MW-1:0]  mprod;
  logic signed [W-1:0]   mq;
  logic                  up;
  logic signed [W-1:0]   apex, lq, rq;
  logic signed [C-1:0]   ty, by;

  logic                  up_n;
  logic signed [W-1:0]   apex_n, lq_n, rq_n;
  logic signed [C-1:0]   ty_n, by_n;
  always_comb begin
    up_n = 1'b0; apex_n = to_q(v0x); lq_n = to_q(v1x); rq_n = to_q(v2x);
    ty_n = v0y; by_n = v1y;
    case (kind)
      KIND_FLAT_BOTTOM: ;
      KIND_FLAT_TOP: begin
        up_n = 1'b1; apex_n = to_q(v2x); lq_n = to_q(v0x); rq_n = to_q(v1x);
        ty_n = v0y; by_n = v2y;
      end
      KIND_SPLIT: begin
        if (cmd.pass) begin
          up_n = 1'b1; apex_n = to_q(v2x); lq_n = to_q(v1x); rq_n = mq;
          ty_n = v1y; by_n = v2y;
        end else begin
          rq_n = mq;
        end
      end
      default: ;
    endcase
  end

  // divider operands
  logic signed [NW-1:0] d_num;
  logic [C-1:0]         d_den;
  logic signed [C:0]    dy_mid, dy_full, dy_pass;
  always_comb begin
    dy_mid  = (C+1)'(v1y) - (C+1)'(v0y);
    dy_full = (C+1)'(v2y) - (C+1)'(v0y);
    dy_pass = (C+1)'(by) - (C+1)'(ty);
    case (cmd.div_sel)
      DSEL_RATIO: begin
        d_num = NW'(dy_mid) <<< FRAC_BITS;
        d_den = dy_full[C-1:0];
      end
      DSEL_S1: begin
        d_num = NW'(lq - apex);
        d_den = dy_pass[C-1:0];
      end
      DSEL_S2: begin
        d_num = NW'(rq - apex);
        d_den = dy_pass[C-1:0];
      end
      default: begin
        d_num = '0;
        d_den = '0;
      end
    endcase
  end

  logic                 div_done;
  logic signed [NW-1:0] quot;
  tssf_div #(.NW(NW), .DW(C)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .num  (d_num),
    .den  (d_den),
    .done (div_done),
    .quot (quot)
  );

  // row range clipped to the band
  logic signed [RW-1:0] lo, hi, ty_w, by_w, tp1;
  logic signed [RW-1:0] rs_n, re_n, n0_w;
  logic                 empty_n;
  always_comb begin
    lo   = RW'(band_top);
    hi   = lo + RW'(BAND_ROWS - 1);
    ty_w = RW'(ty);
    by_w = RW'(by);
    tp1  = ty_w + RW'(1);
    if (up) begin
      rs_n    = (by_w < hi) ? by_w : hi;
      re_n    = (tp1 > lo) ? tp1 : lo;
      empty_n = rs_n < re_n;
      n0_w    = by_w - rs_n;
    end else begin
      rs_n    = (ty_w > lo) ? ty_w : lo;
      re_n    = (by_w < hi) ? by_w : hi;
      empty_n = rs_n > re_n;
      n0_w    = rs_n - ty_w;
    end
  end

  logic signed [W-1:0]  s1, s2;
  logic signed [RW-1:0] rs, re, cur_row;
  logic [C-1:0]         n0;
  logic                 empty;
  logic signed [PW-1:0] p1, p2;
  logic signed [W-1:0]  xa, xb;
  span_t                pend;
  logic                 pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      span_valid <= 1'b0;
    end else begin
      span_valid <= pend_valid && (cmd.step || cmd.flush);
      if (cmd.load) begin
        v0x <= ax2; v0y <= ay2; v1x <= bx2; v1y <= by2; v2x <= cx2; v2y <= cy2;
        colour <= triangle.fill_colour;
      end
      if (div_done) begin
        case (cmd.div_sel)
          DSEL_RATIO: ratio <= quot[FRAC_BITS-1:0];
          DSEL_S1:    s1 <= W'(quot);
          DSEL_S2:    s2 <= W'(quot);
          default: ;
        endcase
      end
      if (cmd.mq_mul) mprod <= $signed({1'b0, ratio}) * ((C+1)'(v2x) - (C+1)'(v0x));
      if (cmd.mq_add) mq <= to_q(v0x) + W'(mprod);
      if (cmd.setup) begin
        up <= up_n; apex <= apex_n; lq <= lq_n; rq <= rq_n; ty <= ty_n; by <= by_n;
      end
      if (cmd.calc_range) begin
        rs    <= rs_n;
        re    <= re_n;
        empty <= empty_n;
        n0    <= n0_w[C-1:0];
      end
      if (cmd.x_mul) begin
        p1 <= $signed({1'b0, n0}) * s1;
        p2 <= $signed({1'b0, n0}) * s2;
      end
      if (cmd.x_init) begin
        xa      <= apex + W'(p1);
        xb      <= apex + HALF + W'(p2);
        cur_row <= rs;
      end
      // one row held back so the final span can be marked
      if (cmd.step) begin
        if (pend_valid) span <= pend;
        pend.row         <= cur_row[C-1:0];
        pend.x_from      <= sat_x(xa);
        pend.x_to        <= sat_x(xb);
        pend.span_colour <= colour;
        pend.last_span   <= 1'b0;
        pend_valid       <= 1'b1;
        xa               <= xa + s1;
        xb               <= xb + s2;
        cur_row          <= up ? (cur_row - RW'(1)) : (cur_row + RW'(1));
      end
      if (cmd.flush && pend_valid) begin
        span       <= {pend[$bits(span_t)-1:1], 1'b1};
        pend_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.kind     = kind;
    status.div_done = div_done;
    status.empty    = empty;
    status.at_end   = cur_row == re;
  end
endmodule

// ----- rtl/tssf_ctrl.sv -----
// controller: sequences setup, divisions and row stepping
`timescale 1ns / 1ps
module tssf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tssf_pkg::dp_status_t status,
  output tssf_pkg::dp_cmd_t    cmd
);
  import tssf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SORTED,
    S_RATIO_GO,
    S_RATIO_WAIT,
    S_MQ_MUL,
    S_MQ_ADD,
    S_SETUP,
    S_S1_GO,
    S_S1_WAIT,
    S_S2_GO,
    S_S2_WAIT,
    S_RANGE,
    S_XMUL,
    S_XINIT,
    S_ROWS,
    S_NEXT
  } state_t;

  state_t state;
  logic   pass;
  logic   flushing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pass     <= 1'b0;
      flushing <= 1'b0;
    end else begin
      flushing <= 1'b0;
      case (state)
        S_IDLE: if (start) state <= S_SORTED;
        S_SORTED: begin
          pass  <= 1'b0;
          state <= (status.kind == KIND_SPLIT) ? S_RATIO_GO : S_SETUP;
        end
        S_RATIO_GO:   state <= S_RATIO_WAIT;
        S_RATIO_WAIT: if (status.div_done) state <= S_MQ_MUL;
        S_MQ_MUL:     state <= S_MQ_ADD;
        S_MQ_ADD:     state <= S_SETUP;
        S_SETUP:      state <= S_S1_GO;
        S_S1_GO:      state <= S_S1_WAIT;
        S_S1_WAIT:    if (status.div_done) state <= S_S2_GO;
        S_S2_GO:      state <= S_S2_WAIT;
        S_S2_WAIT:    if (status.div_done) state <= S_RANGE;
        S_RANGE:      state <= S_XMUL;
        S_XMUL:       state <= status.empty ? S_NEXT : S_XINIT;
        S_XINIT:      state <= S_ROWS;
        S_ROWS:       if (status.at_end) state <= S_NEXT;
        S_NEXT: begin
          if (status.kind == KIND_SPLIT && !pass) begin
            pass  <= 1'b1;
            state <= S_SETUP;
          end else begin
            flushing <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.pass = pass;
    case (state)
      S_IDLE:       cmd.load = start;
      S_RATIO_GO:   cmd.div_go = 1'b1;
      S_MQ_MUL:     cmd.mq_mul = 1'b1;
      S_MQ_ADD:     cmd.mq_add = 1'b1;
      S_SETUP:      cmd.setup = 1'b1;
      S_S1_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DSEL_S1;
      end
      S_S1_WAIT:    cmd.div_sel = DSEL_S1;
      S_S2_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DSEL_S2;
      end
      S_S2_WAIT:    cmd.div_sel = DSEL_S2;
      S_RANGE:      cmd.calc_range = 1'b1;
      S_XMUL:       cmd.x_mul = 1'b1;
      S_XINIT:      cmd.x_init = 1'b1;
      S_ROWS:       cmd.step = 1'b1;
      default: ;
    endcase
    // final span is flushed in the first idle cycle
    if (flushing) cmd.flush = 1'b1;
    busy = state != S_IDLE;
  end
endmodule

// ----- rtl/triangle_scanline_span_fill.sv -----
// top level of the triangle scanline span fill block
`timescale 1ns / 1ps
// usage
//  - a triangle item (three vertices and a colour) is taken on a clock edge
//    with start high and busy low; busy then stays high until the triangle
//    has been stepped through
//  - spans come out on span with span_valid high for exactly one cycle each,
//    bottom-flat part in rising row order, then top-flat part in falling order;
//    the final span of a triangle carries last_span, and a triangle with no
//    row inside the band gives no span at all
//  - the receiver cannot stall: every strobed span is taken at once
//  - band_top_row is written over the cfg channel (cfg_ready is always high)
//    and the user must write it only while the block is idle; the block does
//    not enforce this; it resets to 0
//  - sequencing: each slope division runs on one shared bit-serial divider; a
//    flat triangle needs two divisions before its first row, a split one three
//    divisions, then two divisions between its parts; rows step one per cycle,
//    at most BAND_ROWS, each span leaving at the next step
//  - the last span leaves in the cycle after busy falls, and a new item may be
//    started in that same cycle
//  - reset is synchronous and clears the controller and output strobe
module triangle_scanline_span_fill #(
  parameter int BAND_ROWS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  tssf_pkg::tri_in_t                     triangle,
  output logic                                  span_valid,
  output tssf_pkg::span_t                       span,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic signed [tssf_pkg::COORD_BITS-1:0] cfg_data
);
  import tssf_pkg::*;

  // band register, first row of the output window
  logic signed [COORD_BITS-1:0] band_top_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_top_row <= '0;
    end else if (cfg_valid && cfg_ready) begin
      band_top_row <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  tssf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // arithmetic and span registers
  tssf_dp #(
    .BAND_ROWS (BAND_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .band_top   (band_top_row),
    .triangle   (triangle),
    .cmd        (cmd),
    .status     (status),
    .span_valid (span_valid),
    .span       (span)
  );
endmodule

// ----- rtl/tssf_chk.sv -----
// port-level checker for the triangle span fill block, with its bind
`timescale 1ns / 1ps
`include "triangle_scanline_span_fill_defines.svh"
module tssf_chk #(
  parameter int BAND_ROWS = 64
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  span_valid,
  input tssf_pkg::span_t                       span,
  input logic                                  cfg_valid,
  input logic                                  cfg_ready,
  input logic signed [tssf_pkg::COORD_BITS-1:0] cfg_data
);
  import tssf_pkg::*;

  localparam int RW = COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] band_seen;
  logic signed [RW-1:0]         row_w, lo_w, hi_w;
  logic                         in_band;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_seen <= '0;
    end else if (cfg_valid && cfg_ready) begin
      band_seen <= cfg_data;
    end
  end

  always_comb begin
    row_w   = RW'(span.row);
    lo_w    = RW'(band_seen);
    hi_w    = lo_w + RW'(BAND_ROWS - 1);
    in_band = (row_w >= lo_w) && (row_w <= hi_w);
  end

  `TSSF_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `TSSF_ASSERT_SAME(a_row_in_band, clk, rst, span_valid, in_band)
  `TSSF_ASSERT_NEXT(a_last_quiet, clk, rst, span_valid && span.last_span, !span_valid)
  `TSSF_ASSERT_SAME(a_more_busy, clk, rst, span_valid && !span.last_span, busy)
endmodule

bind triangle_scanline_span_fill tssf_chk #(.BAND_ROWS(BAND_ROWS)) u_chk (.*);
